// ===== sv/rrt_pkg.sv =====
// ----------------------------------------------------------------------------
// rrt_pkg
// shared types and constants of the retransmit request tracker
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam logic [1:0] KIND_STORE = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_SWEEP = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic RES_STORED = 1'b0;
  localparam logic RES_RESEND = 1'b1;

  localparam int PREFIX_LEN = 14;
  localparam logic [16:0] POSITION_MAX = 17'h1FFFF;

  localparam logic [1:0] REG_PACKET_SIZE  = 2'd0;
  localparam logic [1:0] REG_SLOTS_IN_USE = 2'd1;

  // queued input item between front and back
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] msg_byte;
    logic       end_of_message;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MOD,
    ST_SWEEP,
    ST_COMMIT
  } back_state_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] p);
    logic [7:0] c;
    c = 8'h20;
    unique case (p)
      4'd0:  c = "L";
      4'd1:  c = "O";
      4'd2:  c = "U";
      4'd3:  c = "D";
      4'd4:  c = "E";
      4'd5:  c = "R";
      4'd6:  c = "_";
      4'd7:  c = "P";
      4'd8:  c = "L";
      4'd9:  c = "E";
      4'd10: c = "A";
      4'd11: c = "S";
      4'd12: c = "E";
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/rrt_front.sv =====
// ----------------------------------------------------------------------------
// rrt_front
// input item queue that decouples acceptance from the back engine
// ----------------------------------------------------------------------------
module rrt_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  rrt_pkg::item_t in_item,
  output logic           q_valid,
  output rrt_pkg::item_t q_item,
  input  logic           q_take
);

  rrt_pkg::item_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full    = (count == 3'd4);
  assign q_valid = (count != 3'd0);
  assign q_item  = mem[rd_ptr];

  // item storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= in_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 2'd1;
      if (q_take && q_valid) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'((push && !full) ? 1 : 0) - 3'((q_take && q_valid) ? 1 : 0);
    end
  end

endmodule

// ===== sv/rrt_back.sv =====
// ----------------------------------------------------------------------------
// rrt_back
// ring bookkeeping, request parsing, slot division and sweep
// ----------------------------------------------------------------------------
module rrt_back #(
  parameter int MAX_SLOTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    packet_size,
  input  logic [6:0]     slots_in_use,
  input  logic           q_valid,
  input  rrt_pkg::item_t q_item,
  output logic           q_take,
  output logic           empty,
  input  logic           pop,
  output logic           result_kind,
  output logic [5:0]     slot_index,
  output logic           last_of_run
);

  localparam int SW = $clog2(MAX_SLOTS);

  logic [MAX_SLOTS-1:0] resend_marks;
  logic [MAX_SLOTS-1:0] pending_marks;
  logic [31:0] oldest_byte_number;
  logic [SW-1:0] oldest_slot;
  logic [6:0] stored_count;
  logic [16:0] message_position;
  logic [31:0] number_accumulator;
  logic message_valid;
  logic previous_was_digit;

  rrt_pkg::back_state_t state, state_next;
  logic [31:0] quo;
  logic [16:0] rem;
  logic [5:0] quo_mod;
  logic [5:0] bit_cnt;
  logic [6:0] scan;
  logic [6:0] nslots;
  logic [15:0] psize;
  logic commit_valid;

  logic out_full;

  // effective configuration
  always_comb begin
    if (slots_in_use == 7'd0) nslots = 7'd1;
    else if (slots_in_use > 7'(MAX_SLOTS)) nslots = 7'(MAX_SLOTS);
    else nslots = slots_in_use;
    psize = (packet_size == 16'd0) ? 16'd1 : packet_size;
  end

  // ring position and clamped fill; norm is set while the oldest slot still
  // has to be brought below a smaller slot count, one subtraction a cycle
  logic [6:0] os_eff;
  logic [6:0] sc_eff;
  logic norm;
  always_comb begin
    os_eff = 7'(oldest_slot);
    norm = (os_eff >= nslots);
    sc_eff = (stored_count > nslots) ? nslots : stored_count;
  end

  // byte classification
  logic [7:0] b;
  logic eom;
  logic digit;
  logic byte_ok;
  always_comb begin
    b = q_item.msg_byte;
    eom = q_item.end_of_message;
    digit = (b >= "0") && (b <= "9");
    byte_ok = 1'b1;
    if (message_position < 17'(rrt_pkg::PREFIX_LEN)) begin
      byte_ok = (b == rrt_pkg::prefix_char(message_position[3:0])) && !eom;
    end else if (message_position == 17'(rrt_pkg::PREFIX_LEN)) begin
      byte_ok = digit && !eom;
    end else if (eom) begin
      byte_ok = (b == 8'h0A) && previous_was_digit;
    end else begin
      byte_ok = digit || (b == ",");
    end
  end

  // slot arithmetic helpers
  logic [6:0] new_slot_sum;
  logic [6:0] new_slot;
  logic [6:0] os_inc;
  logic [6:0] mod_sum;
  logic [6:0] scan_sum;
  logic [6:0] scan_slot;
  always_comb begin
    new_slot_sum = os_eff + sc_eff;
    new_slot = (new_slot_sum >= nslots) ? new_slot_sum - nslots : new_slot_sum;
    os_inc = (os_eff + 7'd1 >= nslots) ? 7'd0 : os_eff + 7'd1;
    mod_sum = {1'b0, quo_mod} + os_eff;
    if (mod_sum >= nslots) mod_sum = mod_sum - nslots;
    scan_sum = os_eff + scan;
    scan_slot = (scan_sum >= nslots) ? scan_sum - nslots : scan_sum;
  end

  logic [31:0] diff;
  logic [16:0] rsh;
  logic [16:0] rsub;
  logic [6:0] qm_sh;
  assign diff = number_accumulator - oldest_byte_number;
  assign rsh  = {rem[15:0], quo[31]};
  assign rsub = rsh - {1'b0, psize};
  // quotient modulo slot count, built up as the quotient bits come out
  assign qm_sh = {quo_mod, !rsub[16]};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rrt_pkg::ST_IDLE: begin
        if (q_valid && !norm) begin
          if (q_item.kind == rrt_pkg::KIND_STORE) begin
            state_next = rrt_pkg::ST_IDLE;
          end else if (q_item.kind == rrt_pkg::KIND_BYTE) begin
            if (message_position >= 17'(rrt_pkg::PREFIX_LEN) && !digit &&
                number_accumulator >= oldest_byte_number) state_next = rrt_pkg::ST_DIV;
            else if (eom) state_next = rrt_pkg::ST_COMMIT;
          end else if (q_item.kind == rrt_pkg::KIND_SWEEP) begin
            state_next = rrt_pkg::ST_SWEEP;
          end
        end
      end
      rrt_pkg::ST_DIV: if (bit_cnt == 6'd31) state_next = rrt_pkg::ST_MOD;
      rrt_pkg::ST_MOD: state_next = eom ? rrt_pkg::ST_COMMIT : rrt_pkg::ST_IDLE;
      rrt_pkg::ST_SWEEP: begin
        if (!out_full && scan >= sc_eff) state_next = rrt_pkg::ST_IDLE;
      end
      rrt_pkg::ST_COMMIT: state_next = rrt_pkg::ST_IDLE;
      default: state_next = rrt_pkg::ST_IDLE;
    endcase
  end

  // queue take strobe
  always_comb begin
    q_take = 1'b0;
    unique case (state)
      rrt_pkg::ST_IDLE: begin
        if (q_valid && !norm) begin
          if (q_item.kind == rrt_pkg::KIND_STORE) q_take = !out_full;
          else if (q_item.kind == rrt_pkg::KIND_BYTE) q_take = (state_next == rrt_pkg::ST_IDLE);
          else if (q_item.kind != rrt_pkg::KIND_SWEEP) q_take = 1'b1;
        end
      end
      rrt_pkg::ST_MOD: q_take = !eom;
      rrt_pkg::ST_SWEEP: q_take = !out_full && (scan >= sc_eff);
      rrt_pkg::ST_COMMIT: q_take = 1'b1;
      default: q_take = 1'b0;
    endcase
  end

  // next marked slot in the sweep
  logic found;
  assign found = (scan < sc_eff) && resend_marks[scan_slot[SW-1:0]];

  // output register
  logic emit;
  logic emit_kind;
  logic [5:0] emit_slot;
  logic emit_last;
  logic more_marks;
  logic [6:0] mpos;
  always_comb begin
    more_marks = 1'b0;
    mpos = 7'd0;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      mpos = os_eff + 7'(i);
      if (mpos >= nslots) mpos = mpos - nslots;
      if (7'(i) > scan && 7'(i) < sc_eff && resend_marks[mpos[SW-1:0]]) more_marks = 1'b1;
    end
    emit = 1'b0;
    emit_kind = rrt_pkg::RES_STORED;
    emit_slot = 6'(new_slot);
    emit_last = 1'b1;
    if (state == rrt_pkg::ST_IDLE && q_valid && !norm &&
        q_item.kind == rrt_pkg::KIND_STORE && !out_full) begin
      emit = 1'b1;
      emit_slot = (sc_eff < nslots) ? 6'(new_slot) : 6'(os_eff);
    end else if (state == rrt_pkg::ST_SWEEP && !out_full && found) begin
      emit = 1'b1;
      emit_kind = rrt_pkg::RES_RESEND;
      emit_slot = 6'(scan_slot);
      emit_last = !more_marks;
    end
  end

  assign out_full = !empty && !pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else if (emit) begin
      empty <= 1'b0;
    end else if (pop) begin
      empty <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind <= emit_kind;
      slot_index  <= emit_slot;
      last_of_run <= emit_last;
    end
  end

  // main state and bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrt_pkg::ST_IDLE;
      resend_marks <= '0;
      pending_marks <= '0;
      oldest_byte_number <= '0;
      oldest_slot <= '0;
      stored_count <= '0;
      message_position <= '0;
      number_accumulator <= '0;
      message_valid <= 1'b1;
      previous_was_digit <= 1'b0;
      quo <= '0;
      rem <= '0;
      quo_mod <= '0;
      bit_cnt <= '0;
      scan <= '0;
      commit_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        rrt_pkg::ST_IDLE: begin
          stored_count <= sc_eff;
          if (norm) begin
            oldest_slot <= SW'(os_eff - nslots);
          end else if (q_valid && q_item.kind == rrt_pkg::KIND_STORE && !out_full) begin
            if (sc_eff < nslots) begin
              stored_count <= sc_eff + 7'd1;
              resend_marks[new_slot[SW-1:0]] <= 1'b0;
              pending_marks[new_slot[SW-1:0]] <= 1'b0;
            end else begin
              oldest_byte_number <= oldest_byte_number + 32'(psize);
              oldest_slot <= SW'(os_inc);
              resend_marks[os_eff[SW-1:0]] <= 1'b0;
              pending_marks[os_eff[SW-1:0]] <= 1'b0;
            end
          end else if (q_valid && q_item.kind == rrt_pkg::KIND_BYTE) begin
            commit_valid <= message_valid && byte_ok;
            message_valid <= message_valid && byte_ok;
            previous_was_digit <= digit;
            if (message_position < rrt_pkg::POSITION_MAX)
              message_position <= message_position + 17'd1;
            if (message_position >= 17'(rrt_pkg::PREFIX_LEN)) begin
              if (digit) number_accumulator <= number_accumulator * 32'd10 + 32'(b - "0");
              else if (state_next != rrt_pkg::ST_DIV) number_accumulator <= '0;
            end
            quo <= diff;
            rem <= '0;
            quo_mod <= '0;
            bit_cnt <= '0;
            if (eom && state_next == rrt_pkg::ST_IDLE) begin
              // not reached: eom always goes through commit
              pending_marks <= '0;
            end
          end else if (q_valid && q_item.kind == rrt_pkg::KIND_SWEEP) begin
            scan <= '0;
          end
        end
        rrt_pkg::ST_DIV: begin
          // restoring division, one quotient bit a cycle
          bit_cnt <= bit_cnt + 6'd1;
          if (!rsub[16]) begin
            rem <= rsub;
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= rsh;
            quo <= {quo[30:0], 1'b0};
          end
          quo_mod <= 6'((qm_sh >= nslots) ? qm_sh - nslots : qm_sh);
        end
        rrt_pkg::ST_MOD: begin
          // place the mark at the oldest slot plus the reduced quotient
          pending_marks[mod_sum[SW-1:0]] <= 1'b1;
          number_accumulator <= '0;
        end
        rrt_pkg::ST_SWEEP: begin
          if (!out_full) begin
            if (scan >= sc_eff) resend_marks <= '0;
            else scan <= scan + 7'd1;
          end
        end
        rrt_pkg::ST_COMMIT: begin
          if (commit_valid) resend_marks <= resend_marks | pending_marks;
          pending_marks <= '0;
          message_position <= '0;
          number_accumulator <= '0;
          message_valid <= 1'b1;
          previous_was_digit <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/retransmit_request_tracker.sv =====
// a stored-packet item has its slot registered onto the result ports as it leaves the queue
// items are handled one at a time; a byte that closes a number runs through the
// divider and the slot mark, and the last byte of a message through the commit;
// a sweep scans each stored slot in turn and waits while the result register is full;
// after a slot-count change the first item waits until the oldest slot is below it; 4-entry queue
// reset (rst, synchronous) clears marks, ring pointers and parser state
// ----------------------------------------------------------------------------
// retransmit_request_tracker
// slot ring tracker with retransmit request parsing
// ----------------------------------------------------------------------------
module retransmit_request_tracker #(
  parameter int MAX_SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind,
  input  logic [7:0]  msg_byte,
  input  logic        end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind,
  output logic [5:0]  slot_index,
  output logic        last_of_run
);

  logic [15:0] packet_size;
  logic [6:0]  slots_in_use;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      packet_size  <= 16'd512;
      slots_in_use <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == rrt_pkg::REG_PACKET_SIZE) packet_size <= cfg_data;
      else if (cfg_index == rrt_pkg::REG_SLOTS_IN_USE) slots_in_use <= cfg_data[6:0];
    end
  end

  rrt_pkg::item_t in_item, q_item;
  logic q_valid, q_take;
  assign in_item = '{kind: kind, msg_byte: msg_byte, end_of_message: end_of_message};

  rrt_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  rrt_back #(.MAX_SLOTS(MAX_SLOTS)) u_back (
    .clk(clk), .rst(rst), .packet_size(packet_size), .slots_in_use(slots_in_use),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take),
    .empty(empty), .pop(pop), .result_kind(result_kind),
    .slot_index(slot_index), .last_of_run(last_of_run)
  );

endmodule

// ===== tb/sv/rrt_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrt_checker
// watches the item and result channels of the retransmit request tracker,
// keeps its own copy of the ring and parser state, predicts every result
// slot and compares each popped result with the oldest prediction
// ----------------------------------------------------------------------------
module rrt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  kind,
  input  logic [7:0]  msg_byte,
  input  logic        end_of_message,
  input  logic        empty,
  input  logic        pop,
  input  logic        result_kind,
  input  logic [5:0]  slot_index,
  input  logic        last_of_run,
  output int          fail_count,
  output int          pending_results
);

  typedef struct packed {
    logic       rkind;
    logic [5:0] slot;
    logic       last;
  } slot_result_t;

  slot_result_t expected_slots[$];

  // model copy of the tracker
  logic [15:0] psize;
  logic [6:0]  ring_len;
  logic [63:0] resend;
  logic [63:0] pend;
  logic [31:0] oldest_bn;
  logic [6:0]  oldest;
  logic [6:0]  stored;
  logic [16:0] msg_pos;
  logic [31:0] number;
  logic        msg_ok;
  logic        was_digit;

  assign pending_results = expected_slots.size();

  // close the number being parsed into a pending mark
  task automatic mark_number(input int n);
    logic [31:0] step;
    logic [31:0] diff;
    step = (psize == 0) ? 32'd1 : {16'd0, psize};
    if (number >= oldest_bn) begin
      diff = (number - oldest_bn) / step;
      pend[(64'(oldest % n) + 64'(diff)) % n] = 1'b1;
    end
    number = '0;
  endtask

  task automatic track_item(input logic [1:0] k, input logic [7:0] b, input logic eom);
    int n;
    int slot;
    int hits;
    int p;
    logic dig;
    slot_result_t r;
    n = (ring_len < 1) ? 1 : (ring_len > 64) ? 64 : ring_len;
    oldest = 7'(oldest % n);
    if (stored > n) stored = 7'(n);
    case (k)
      rrt_pkg::KIND_STORE: begin
        if (stored < n) begin
          slot = (oldest + stored) % n;
          stored++;
        end else begin
          slot = oldest;
          oldest_bn += (psize == 0) ? 32'd1 : {16'd0, psize};
          oldest = 7'((oldest + 1) % n);
        end
        resend[slot] = 1'b0;
        pend[slot] = 1'b0;
        r.rkind = rrt_pkg::RES_STORED;
        r.slot = 6'(slot);
        r.last = 1'b1;
        expected_slots.push_back(r);
      end
      rrt_pkg::KIND_BYTE: begin
        p = msg_pos;
        dig = (b >= "0" && b <= "9");
        if (p < rrt_pkg::PREFIX_LEN) begin
          if (b != rrt_pkg::prefix_char(4'(p)) || eom) msg_ok = 1'b0;
        end else if (p == rrt_pkg::PREFIX_LEN) begin
          if (!dig || eom) msg_ok = 1'b0;
        end else if (eom) begin
          if (b != 8'h0A || !was_digit) msg_ok = 1'b0;
        end else if (!dig && b != ",") begin
          msg_ok = 1'b0;
        end
        if (p >= rrt_pkg::PREFIX_LEN) begin
          if (dig) number = number * 10 + (b - "0");
          else mark_number(n);
        end
        was_digit = dig;
        if (msg_pos != rrt_pkg::POSITION_MAX) msg_pos++;
        if (eom) begin
          if (msg_ok) resend |= pend;
          pend = '0;
          msg_pos = '0;
          number = '0;
          msg_ok = 1'b1;
          was_digit = 1'b0;
        end
      end
      rrt_pkg::KIND_SWEEP: begin
        hits = 0;
        for (int i = 0; i < stored; i++) begin
          slot = (oldest + i) % n;
          if (resend[slot]) begin
            r.rkind = rrt_pkg::RES_RESEND;
            r.slot = 6'(slot);
            r.last = 1'b0;
            expected_slots.push_back(r);
            hits++;
          end
        end
        resend = '0;
        if (hits > 0) expected_slots[$].last = 1'b1;
      end
      default: ;
    endcase
  endtask

  // predict on accepted items and config writes, compare on accepted results
  always @(posedge clk) begin
    slot_result_t want;
    if (rst) begin
      psize = 16'd512;
      ring_len = 7'd64;
      resend = '0;
      pend = '0;
      oldest_bn = '0;
      oldest = '0;
      stored = '0;
      msg_pos = '0;
      number = '0;
      msg_ok = 1'b1;
      was_digit = 1'b0;
      expected_slots.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rrt_pkg::REG_PACKET_SIZE) psize = cfg_data;
        else if (cfg_index == rrt_pkg::REG_SLOTS_IN_USE) ring_len = cfg_data[6:0];
      end
      if (pop && !empty) begin
        if (expected_slots.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result kind=%0d slot=%0d last=%0d",
                     result_kind, slot_index, last_of_run);
        end else begin
          want = expected_slots.pop_front();
          if (want.rkind !== result_kind || want.slot !== slot_index ||
              want.last !== last_of_run) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: expected kind=%0d slot=%0d last=%0d, got %0d %0d %0d",
                       want.rkind, want.slot, want.last,
                       result_kind, slot_index, last_of_run);
          end
        end
      end
      if (push && !full) track_item(kind, msg_byte, end_of_message);
    end
  end

endmodule

// ===== tb/sv/tb_retransmit_request_tracker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_retransmit_request_tracker
// drives stored-packet events, retransmit request datagrams (well formed and
// broken) and sweeps through several register settings; rrt_checker predicts
// and compares, this module gives the verdict
// ----------------------------------------------------------------------------
module tb_retransmit_request_tracker;

  localparam int CYCLE_LIMIT = 1500000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rrt_pkg::REG_PACKET_SIZE;
  logic [15:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  kind = rrt_pkg::KIND_STORE;
  logic [7:0]  msg_byte = '0;
  logic        end_of_message = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        result_kind;
  logic [5:0]  slot_index;
  logic        last_of_run;
  int          fail_count;
  int          pending_results;
  int          cycle_count = 0;
  bit          rx_hold = 1'b0;
  bit          calm = 1'b0;
  string       req_prefix;

  always #4 clk = ~clk;

  retransmit_request_tracker uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .push, .full, .kind, .msg_byte,
    .end_of_message, .empty, .pop, .result_kind, .slot_index, .last_of_run
  );

  rrt_checker checker_i (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .push, .full, .kind, .msg_byte,
    .end_of_message, .empty, .pop, .result_kind, .slot_index, .last_of_run,
    .fail_count, .pending_results
  );

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst || rx_hold) pop <= 1'b0;
    else pop <= calm || ($urandom_range(99) >= 11);
  end

  // request text prefix, one character at a time
  function automatic string request_prefix();
    string s;
    s = "";
    for (int i = 0; i < rrt_pkg::PREFIX_LEN; i++)
      s = {s, $sformatf("%c", rrt_pkg::prefix_char(4'(i)))};
    return s;
  endfunction

  task automatic send(input logic [1:0] k, input logic [7:0] b, input logic eom);
    while (!calm && $urandom_range(99) < 11) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    kind <= k;
    msg_byte <= b;
    end_of_message <= eom;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (600) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit close);
    for (int i = 0; i < s.len(); i++) send(rrt_pkg::KIND_BYTE, s[i], 1'b0);
    if (close) send(rrt_pkg::KIND_BYTE, 8'h0A, 1'b1);
  endtask

  // well formed request for random numbers near the stored window
  task automatic send_request(input int base, input int span);
    int cnt;
    string s;
    cnt = $urandom_range(1, 4);
    s = req_prefix;
    for (int i = 0; i < cnt; i++) begin
      if (i > 0) s = {s, ","};
      if ($urandom_range(9) == 0) s = {s, $sformatf("%0d", $urandom())};
      else s = {s, $sformatf("%0d", base + $urandom_range(span))};
    end
    send_text(s, 1'b1);
  endtask

  task automatic random_phase(input int items, input int psz, input int nslots);
    int r;
    for (int i = 0; i < items; i++) begin
      calm = (i > items / 2 && i < items / 2 + 40);
      r = $urandom_range(99);
      if (r < 45) send(rrt_pkg::KIND_STORE, 8'($urandom()), 1'($urandom()));
      else if (r < 55) send_request(0, psz * nslots * 3);
      else if (r < 70) send(rrt_pkg::KIND_SWEEP, 8'($urandom()), 1'($urandom()));
      else if (r < 80) send(rrt_pkg::KIND_BYTE, 8'($urandom()), $urandom_range(3) == 0);
      else if (r < 85) send(rrt_pkg::KIND_NONE, 8'($urandom()), 1'($urandom()));
      else if (r < 90) send_text({req_prefix, "1,2x"}, 1'b1);
      else send(rrt_pkg::KIND_STORE, 8'd0, 1'b0);
    end
    calm = 1'b0;
  endtask

  initial begin
    req_prefix = request_prefix();
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part with packet size 1 and four slots
    write_reg(rrt_pkg::REG_PACKET_SIZE, 16'd1);
    write_reg(rrt_pkg::REG_SLOTS_IN_USE, 16'd4);
    for (int i = 0; i < 6; i++) send(rrt_pkg::KIND_STORE, 8'hFF, 1'b1);
    send_text({req_prefix, "2,,5"}, 1'b1);
    send(rrt_pkg::KIND_SWEEP, 8'd0, 1'b0);
    send_text({req_prefix, "3"}, 1'b0);
    send(rrt_pkg::KIND_BYTE, 8'h0A, 1'b1);
    send(rrt_pkg::KIND_SWEEP, 8'hFF, 1'b1);
    send_text(req_prefix.substr(0, 5), 1'b1);
    send(rrt_pkg::KIND_NONE, 8'hFF, 1'b1);
    send(rrt_pkg::KIND_SWEEP, 8'd0, 1'b0);
    drain();

    // zero size, one slot, then max values
    write_reg(rrt_pkg::REG_PACKET_SIZE, 16'd0);
    write_reg(rrt_pkg::REG_SLOTS_IN_USE, 16'd0);
    random_phase(10, 1, 1);
    drain();
    write_reg(rrt_pkg::REG_PACKET_SIZE, 16'hFFFF);
    write_reg(rrt_pkg::REG_SLOTS_IN_USE, 16'h7F);
    random_phase(15, 65535, 64);
    drain();

    // long hold-off on the result side so the input queue fills
    fork
      begin
        rx_hold = 1'b1;
        repeat (200) @(negedge clk);
        rx_hold = 1'b0;
      end
    join_none
    for (int i = 0; i < 30; i++) send(rrt_pkg::KIND_STORE, 8'd0, 1'b0);
    drain();

    write_reg(rrt_pkg::REG_PACKET_SIZE, 16'd3);
    write_reg(rrt_pkg::REG_SLOTS_IN_USE, 16'd5);
    random_phase(23, 3, 5);
    drain();
    write_reg(rrt_pkg::REG_PACKET_SIZE, 16'd100);
    write_reg(rrt_pkg::REG_SLOTS_IN_USE, 16'd64);
    random_phase(23, 100, 64);
    drain();

    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
